>>> design/rfc_pkg.sv
`default_nettype none
package rfc_pkg;

   // fixed point format
   localparam int FRAC_BITS = 16;
   localparam int SQ_W      = 64 - FRAC_BITS;

   // clamp limit of f(x) and normalize limit of the chord operands
   localparam logic signed [65:0] F_LIM   = 66'sd1 <<< 62;
   localparam logic signed [65:0] ONE_FX  = 66'sd1 <<< FRAC_BITS;
   localparam logic [62:0]        CM_SAT  = 63'd1 << 62;
   localparam logic [62:0]        NORM_LIM = 63'd1 << 30;
   localparam logic [30:0]        ERR_MAX = 31'h7FFF_FFFF;

   // register reset values
   localparam logic [30:0] TOL_RST   = 31'd66;
   localparam logic [7:0]  MAXIT_RST = 8'd64;

   // register indexes
   localparam logic [1:0] CSR_TOL   = 2'd0;
   localparam logic [1:0] CSR_MODE  = 2'd1;
   localparam logic [1:0] CSR_MAXIT = 2'd2;

   // result status codes
   localparam logic [1:0] STAT_CONV  = 2'd0;
   localparam logic [1:0] STAT_EXACT = 2'd1;
   localparam logic [1:0] STAT_NOCHG = 2'd2;
   localparam logic [1:0] STAT_LIMIT = 2'd3;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQ,
      ST_LO,
      ST_HI,
      ST_CUBE,
      ST_FX,
      ST_CHECK,
      ST_ITER,
      ST_NORM,
      ST_PROD,
      ST_DIV,
      ST_CHORD,
      ST_UPDATE,
      ST_ERR,
      ST_TEST,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      EV_FA,
      EV_FB,
      EV_FC
   } eval_type;

   typedef enum logic {
      DV_CHORD,
      DV_PCT
   } div_type;

endpackage
`default_nettype wire

>>> design/regula_falsi_cubic_root.sv
`default_nettype none
// Sequence: with no sign change across the bracket, two cubic evaluations, a sign check,
//   then done. Each iteration normalizes the chord operands, runs a radix-2 restoring
//   divide and one cubic evaluation, plus a percent divide in percent mode when the chord
//   point is nonzero; a degenerate chord skips the divide. Capped at max_iterations.
// Throughput: one bracket at a time; the next can be taken in the cycle after the result loads.
// Reset: synchronous, active high; tolerance 66, absolute mode, cap 64; no result pending.
module regula_falsi_cubic_root (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [63:0] req_tdata,   // left_end[31:0], right_end[63:32]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [71:0]      rsp_tdata,   // root[31:0], error_estimate[62:32],
                                         // iterations[70:63], zero pad
   output logic [1:0]       rsp_tuser,   // status[1:0]
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_addr,
   input  wire logic [30:0] csr_wdata
);
   import rfc_pkg::*;

   state_type state_ff, state_in;
   eval_type  ev_ff, ev_in;
   div_type   dv_ff, dv_in;

   logic [30:0] tol_ff;
   logic        mode_ff;
   logic [7:0]  maxit_ff;

   logic signed [31:0] a_ff, a_in, b_ff, b_in, x_ff, x_in;
   logic signed [31:0] c_ff, c_in, cprev_ff, cprev_in;
   logic signed [63:0] fa_ff, fa_in, fb_ff, fb_in, fc_ff, fc_in;
   logic [63:0]        prod_ff, prod_in, acc_ff, acc_in;
   logic [SQ_W-1:0]    sq_ff, sq_in;
   logic [62:0]        cm_ff, cm_in, ma_ff, ma_in, mb_ff, mb_in;
   logic [63:0]        err_ff, err_in, quo_ff, quo_in;
   logic [31:0]        rem_ff, rem_in, dden_ff, dden_in;
   logic [5:0]         dcnt_ff, dcnt_in;
   logic [7:0]         iter_ff, iter_in;
   logic               neg_ff, neg_in;
   logic [1:0]         stat_ff, stat_in;

   logic [31:0] root_ff, root_in;
   logic [30:0] oerr_ff, oerr_in;
   logic [7:0]  oiter_ff, oiter_in;
   logic [1:0]  ostat_ff, ostat_in;
   logic        rsp_valid_ff, rsp_valid_in;

   // shared multiplier
   logic [32:0] mul_x, mul_y;
   logic [65:0] mul_p;

   // helper values
   logic [7:0]         cap;
   logic [31:0]        m_abs;
   logic [63:0]        sq_w;
   logic [95:0]        full;
   logic signed [65:0] xe, cube, f66, f_cl;
   logic signed [30:0] sa, sb;
   logic signed [31:0] den;
   logic [31:0]        den_abs;
   logic signed [32:0] ba;
   logic [32:0]        ba_abs;
   logic signed [33:0] qs, csum;
   logic signed [32:0] diff;
   logic [32:0]        dmag;
   logic [39:0]        d100;
   logic [32:0]        trial;
   logic               trial_ok;
   logic               fa_pos, fa_neg, fb_pos, fb_neg, fc_pos, fc_neg;
   logic               load_out;

   assign cap    = (maxit_ff == 8'd0) ? 8'd1 : maxit_ff;
   assign m_abs  = x_ff[31] ? 32'(-x_ff) : 32'(x_ff);
   assign sq_w   = prod_ff >> FRAC_BITS;
   assign full   = {prod_ff, 32'd0} + {32'd0, acc_ff};
   assign xe     = 66'(x_ff);
   assign cube   = x_ff[31] ? -$signed({3'd0, cm_ff}) : $signed({3'd0, cm_ff});
   assign f66    = cube - (xe <<< 3) + xe + ONE_FX;
   assign f_cl   = (f66 > F_LIM) ? F_LIM : ((f66 < -F_LIM) ? -F_LIM : f66);
   assign sa     = fa_ff[63] ? -$signed({1'b0, ma_ff[29:0]}) : $signed({1'b0, ma_ff[29:0]});
   assign sb     = fb_ff[63] ? -$signed({1'b0, mb_ff[29:0]}) : $signed({1'b0, mb_ff[29:0]});
   assign den    = 32'(sa) - 32'(sb);
   assign den_abs = den[31] ? 32'(-den) : 32'(den);
   assign ba     = 33'(b_ff) - 33'(a_ff);
   assign ba_abs = ba[32] ? 33'(-ba) : 33'(ba);
   assign qs     = neg_ff ? -$signed({1'b0, quo_ff[32:0]}) : $signed({1'b0, quo_ff[32:0]});
   assign csum   = 34'(a_ff) + qs;
   assign diff   = 33'(c_ff) - 33'(cprev_ff);
   assign dmag   = diff[32] ? 33'(-diff) : 33'(diff);
   assign d100   = ({7'd0, dmag} << 6) + ({7'd0, dmag} << 5) + ({7'd0, dmag} << 2);
   assign trial  = {rem_ff, quo_ff[63]};
   assign trial_ok = trial >= {1'b0, dden_ff};
   assign fa_pos = (fa_ff > 0);
   assign fa_neg = fa_ff[63];
   assign fb_pos = (fb_ff > 0);
   assign fb_neg = fb_ff[63];
   assign fc_pos = (fc_ff > 0);
   assign fc_neg = fc_ff[63];
   assign load_out = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_tready);

   // multiplier operand select
   always_comb begin
      mul_x = 33'd0;
      mul_y = 33'd0;
      case (state_ff)
         ST_SQ: begin
            mul_x = {1'b0, m_abs};
            mul_y = {1'b0, m_abs};
         end
         ST_LO: begin
            mul_x = {1'b0, sq_w[31:0]};
            mul_y = {1'b0, m_abs};
         end
         ST_HI: begin
            mul_x = 33'(sq_ff[SQ_W-1:32]);
            mul_y = {1'b0, m_abs};
         end
         ST_PROD: begin
            mul_x = ba_abs;
            mul_y = {3'd0, ma_ff[29:0]};
         end
         default: begin
            mul_x = 33'd0;
         end
      endcase
   end
   assign mul_p = mul_x * mul_y;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (req_tvalid) state_in = ST_SQ;
         ST_SQ:    state_in = ST_LO;
         ST_LO:    state_in = ST_HI;
         ST_HI:    state_in = ST_CUBE;
         ST_CUBE:  state_in = ST_FX;
         ST_FX: begin
            case (ev_ff)
               EV_FA:   state_in = ST_SQ;
               EV_FB:   state_in = ST_CHECK;
               default: state_in = ST_UPDATE;
            endcase
         end
         ST_CHECK: begin
            if ((fa_pos && fb_pos) || (fa_neg && fb_neg)) state_in = ST_DONE;
            else state_in = ST_ITER;
         end
         ST_ITER:  state_in = (fa_ff == fb_ff) ? ST_SQ : ST_NORM;
         ST_NORM: begin
            if (ma_ff < NORM_LIM && mb_ff < NORM_LIM) state_in = ST_PROD;
         end
         ST_PROD:  state_in = (den == 32'sd0) ? ST_SQ : ST_DIV;
         ST_DIV: begin
            if (dcnt_ff == 6'd63) state_in = (dv_ff == DV_CHORD) ? ST_CHORD : ST_ERR;
         end
         ST_CHORD: state_in = ST_SQ;
         ST_UPDATE: begin
            if (fc_ff == 64'sd0) state_in = ST_DONE;
            else if (mode_ff && c_ff != 32'sd0) state_in = ST_DIV;
            else state_in = ST_TEST;
         end
         ST_ERR:   state_in = ST_TEST;
         ST_TEST: begin
            if (err_ff <= {33'd0, tol_ff} || iter_ff >= cap) state_in = ST_DONE;
            else state_in = ST_ITER;
         end
         ST_DONE:  if (load_out) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // datapath updates
   always_comb begin
      ev_in = ev_ff;     dv_in = dv_ff;
      a_in = a_ff;       b_in = b_ff;       x_in = x_ff;
      c_in = c_ff;       cprev_in = cprev_ff;
      fa_in = fa_ff;     fb_in = fb_ff;     fc_in = fc_ff;
      prod_in = prod_ff; acc_in = acc_ff;   sq_in = sq_ff;   cm_in = cm_ff;
      ma_in = ma_ff;     mb_in = mb_ff;
      err_in = err_ff;   quo_in = quo_ff;   rem_in = rem_ff; dden_in = dden_ff;
      dcnt_in = dcnt_ff; iter_in = iter_ff; neg_in = neg_ff; stat_in = stat_ff;
      case (state_ff)
         ST_IDLE: begin
            a_in = req_tdata[31:0];
            b_in = req_tdata[63:32];
            x_in = req_tdata[31:0];
            cprev_in = req_tdata[31:0];
            c_in = 32'sd0;
            err_in = 64'd0;
            iter_in = 8'd0;
            ev_in = EV_FA;
         end
         ST_SQ: prod_in = mul_p[63:0];
         ST_LO: begin
            sq_in = sq_w[SQ_W-1:0];
            prod_in = mul_p[63:0];
         end
         ST_HI: begin
            acc_in = prod_ff;
            prod_in = mul_p[63:0];
         end
         ST_CUBE: begin
            if (full[95:64] != 32'd0) cm_in = CM_SAT;
            else cm_in = 63'(full[63:0] >> FRAC_BITS);
         end
         ST_FX: begin
            case (ev_ff)
               EV_FA: begin
                  fa_in = f_cl[63:0];
                  x_in = b_ff;
                  ev_in = EV_FB;
               end
               EV_FB:   fb_in = f_cl[63:0];
               default: fc_in = f_cl[63:0];
            endcase
         end
         ST_CHECK: begin
            if ((fa_pos && fb_pos) || (fa_neg && fb_neg)) stat_in = STAT_NOCHG;
         end
         ST_ITER: begin
            iter_in = iter_ff + 8'd1;
            ma_in = fa_neg ? 63'(-fa_ff) : 63'(fa_ff);
            mb_in = fb_neg ? 63'(-fb_ff) : 63'(fb_ff);
            // both ends equal (both zero): chord point is the left end
            if (fa_ff == fb_ff) begin
               c_in = a_ff;
               x_in = a_ff;
               ev_in = EV_FC;
            end
         end
         ST_NORM: begin
            if (!(ma_ff < NORM_LIM && mb_ff < NORM_LIM)) begin
               ma_in = ma_ff >> 1;
               mb_in = mb_ff >> 1;
            end
         end
         ST_PROD: begin
            if (den == 32'sd0) begin
               c_in = a_ff;
               x_in = a_ff;
               ev_in = EV_FC;
            end else begin
               quo_in = mul_p[63:0];
               rem_in = 32'd0;
               dden_in = den_abs;
               dcnt_in = 6'd0;
               neg_in = ba[32] ^ fa_neg ^ den[31];
               dv_in = DV_CHORD;
            end
         end
         ST_DIV: begin
            // one restoring step per cycle
            rem_in = trial_ok ? 32'(trial - {1'b0, dden_ff}) : trial[31:0];
            quo_in = {quo_ff[62:0], trial_ok};
            dcnt_in = dcnt_ff + 6'd1;
         end
         ST_CHORD: begin
            c_in = csum[31:0];
            x_in = csum[31:0];
            ev_in = EV_FC;
         end
         ST_UPDATE: begin
            if (fc_ff == 64'sd0) begin
               err_in = 64'd0;
               stat_in = STAT_EXACT;
            end else begin
               if ((fa_neg && fc_pos) || (fa_pos && fc_neg)) begin
                  b_in = c_ff;
                  fb_in = fc_ff;
               end else begin
                  a_in = c_ff;
                  fa_in = fc_ff;
               end
               cprev_in = c_ff;
               if (!mode_ff) begin
                  err_in = 64'(dmag);
               end else if (c_ff != 32'sd0) begin
                  quo_in = 64'(d100) << FRAC_BITS;
                  rem_in = 32'd0;
                  dden_in = c_ff[31] ? 32'(-c_ff) : 32'(c_ff);
                  dcnt_in = 6'd0;
                  dv_in = DV_PCT;
               end else begin
                  err_in = 64'(d100);
               end
            end
         end
         ST_ERR: err_in = quo_ff;
         ST_TEST: begin
            if (err_ff <= {33'd0, tol_ff}) stat_in = STAT_CONV;
            else if (iter_ff >= cap) stat_in = STAT_LIMIT;
         end
         default: begin
            stat_in = stat_ff;
         end
      endcase
   end

   // result register, loaded while the previous beat drains
   always_comb begin
      root_in = root_ff;
      oerr_in = oerr_ff;
      oiter_in = oiter_ff;
      ostat_in = ostat_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (load_out) begin
         root_in = c_ff;
         oerr_in = (err_ff[63:31] != 33'd0) ? ERR_MAX : err_ff[30:0];
         oiter_in = iter_ff;
         ostat_in = stat_ff;
         rsp_valid_in = 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         tol_ff <= TOL_RST;
         mode_ff <= 1'b0;
         maxit_ff <= MAXIT_RST;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_addr)
               CSR_TOL:   tol_ff <= csr_wdata;
               CSR_MODE:  mode_ff <= csr_wdata[0];
               CSR_MAXIT: maxit_ff <= csr_wdata[7:0];
               default:   tol_ff <= tol_ff;
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      ev_ff <= ev_in;       dv_ff <= dv_in;
      a_ff <= a_in;         b_ff <= b_in;       x_ff <= x_in;
      c_ff <= c_in;         cprev_ff <= cprev_in;
      fa_ff <= fa_in;       fb_ff <= fb_in;     fc_ff <= fc_in;
      prod_ff <= prod_in;   acc_ff <= acc_in;   sq_ff <= sq_in;   cm_ff <= cm_in;
      ma_ff <= ma_in;       mb_ff <= mb_in;
      err_ff <= err_in;     quo_ff <= quo_in;   rem_ff <= rem_in; dden_ff <= dden_in;
      dcnt_ff <= dcnt_in;   iter_ff <= iter_in; neg_ff <= neg_in; stat_ff <= stat_in;
      root_ff <= root_in;   oerr_ff <= oerr_in; oiter_ff <= oiter_in;
      ostat_ff <= ostat_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, oiter_ff, oerr_ff, root_ff};
   assign rsp_tuser  = ostat_ff;

`ifndef SYNTH
   // divider never runs with a zero divisor
   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (dden_ff != 32'd0))
      else $error("divide by zero in sequencer");

   // iteration count never passes the cap
   a_iter_cap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |-> (iter_ff <= cap))
      else $error("iteration count beyond cap");

   // a finished bracket leaves at most one pending result
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      load_out |=> rsp_valid_ff && (state_ff == ST_IDLE))
      else $error("result load lost");
`endif

endmodule
`default_nettype wire
